FILE: hdl/scope_trigger_capture_assert.svh
// Assertion macros shared by the checker of the scope trigger capture block.
`ifndef SCOPE_TRIGGER_CAPTURE_ASSERT_SVH
`define SCOPE_TRIGGER_CAPTURE_ASSERT_SVH

// Clocked property with an active-low reset that disables the check.
`define STC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never hold at a clock edge outside reset.
`define STC_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/stc_pkg.sv
// Package with the constants, types and helper functions of the scope trigger capture block.
package stc_pkg;

    // Ring geometry and window size.
    localparam int BUFFER_DEPTH = 2048;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int WINDOW       = 64;
    localparam int HALF_WIN     = WINDOW / 2;
    localparam int SEARCH_SPAN  = BUFFER_DEPTH / 2;

    // Field widths.
    localparam int SAMPLE_W    = 12;
    localparam int POS_W       = 6;
    localparam int ERR_W       = 16;
    localparam int S_TDATA_W   = 16;
    localparam int M_TDATA_W   = 40;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 12;

    // Typed constants used in address and count arithmetic.
    localparam logic [ADDR_W-1:0]   NEWEST_RESET = ADDR_W'(BUFFER_DEPTH - 1);
    localparam logic [ADDR_W-1:0]   SPAN_LAST    = ADDR_W'(SEARCH_SPAN);
    localparam logic [ADDR_W-1:0]   HALF_WIN_A   = ADDR_W'(HALF_WIN);
    localparam logic [POS_W-1:0]    POS_LAST     = POS_W'(WINDOW - 1);
    localparam logic [ERR_W-1:0]    ERR_MAX      = {ERR_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] LEVEL_RESET  = SAMPLE_W'(2048);

    // Input kinds carried in s_tuser.
    localparam logic ACT_STORE   = 1'b0;
    localparam logic ACT_CAPTURE = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_LEVEL = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RISING_EDGE   = CFG_IDX_W'(1);

    // Trigger settings handed to the controller.
    typedef struct packed {
        logic [SAMPLE_W-1:0] level;
        logic                rising;
    } cfg_t;

    // Access request from the controller to the sample ring.
    typedef struct packed {
        logic                wr_en;
        logic [ADDR_W-1:0]   wr_addr;
        logic [SAMPLE_W-1:0] wr_data;
        logic                rd_en;
        logic [ADDR_W-1:0]   rd_addr;
    } ring_req_t;

    // Edge test between the sample at the candidate point and the one before it.
    function automatic logic is_edge(input logic [SAMPLE_W-1:0] cur,
                                     input logic [SAMPLE_W-1:0] prev,
                                     input cfg_t cfg);
        logic hit;
        if (cfg.rising) begin
            hit = (cur >= cfg.level) && (prev < cfg.level);
        end else begin
            hit = (cur <= cfg.level) && (prev > cfg.level);
        end
        return hit;
    endfunction

endpackage

FILE: hdl/stc_ring.sv
// Sample ring memory with registered read and a fill count that stands for the zero reset.
module stc_ring (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  stc_pkg::ring_req_t              req,
    output logic [stc_pkg::SAMPLE_W-1:0]    rd_data
);

    logic [stc_pkg::SAMPLE_W-1:0] mem [stc_pkg::BUFFER_DEPTH];
    logic [stc_pkg::SAMPLE_W-1:0] q_reg;
    logic                         rd_valid_reg;
    logic                         rd_valid_next;
    logic [stc_pkg::ADDR_W:0]     fill_reg;
    logic [stc_pkg::ADDR_W:0]     fill_next;

    // Writes go to consecutive addresses from zero, so entries below the fill count are written.
    always_comb begin
        fill_next = fill_reg;
        if (req.wr_en && !fill_reg[stc_pkg::ADDR_W]) begin
            fill_next = fill_reg + 1'b1;
        end
        rd_valid_next = fill_reg[stc_pkg::ADDR_W] ||
                        (req.rd_addr < fill_reg[stc_pkg::ADDR_W-1:0]);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    // Memory array: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            q_reg        <= mem[req.rd_addr];
            rd_valid_reg <= rd_valid_next;
        end
    end

    // Entries never written read as zero.
    assign rd_data = rd_valid_reg ? q_reg : '0;

endmodule

FILE: hdl/stc_ctrl.sv
// Controller: sample store, backward trigger search and window readout over the ring.
module stc_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  stc_pkg::cfg_t                   cfg,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stc_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stc_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast,
    output stc_pkg::ring_req_t              ring_req,
    input  logic [stc_pkg::SAMPLE_W-1:0]    ring_data
);

    typedef enum logic [4:0] {
        ST_IDLE     = 5'b00001,
        ST_SEARCH   = 5'b00010,
        ST_WIN_RD   = 5'b00100,
        ST_WIN_LOAD = 5'b01000,
        ST_WIN_SEND = 5'b10000
    } state_t;

    state_t                          state_reg, state_next;
    logic [stc_pkg::ADDR_W-1:0]      newest_reg, newest_next;
    logic [stc_pkg::ERR_W-1:0]       err_reg, err_next;
    logic [stc_pkg::ADDR_W-1:0]      start_reg, start_next;
    logic [stc_pkg::ADDR_W-1:0]      issue_reg, issue_next;
    logic                            chk_valid_reg, chk_valid_next;
    logic                            chk_last_reg, chk_last_next;
    logic [stc_pkg::ADDR_W-1:0]      chk_t_reg, chk_t_next;
    logic [stc_pkg::SAMPLE_W-1:0]    last_q_reg, last_q_next;
    logic [stc_pkg::ADDR_W-1:0]      begin_reg, begin_next;
    logic [stc_pkg::POS_W-1:0]       pos_reg, pos_next;
    logic                            found_reg, found_next;
    logic                            m_valid_reg, m_valid_next;
    logic [stc_pkg::SAMPLE_W-1:0]    m_sample_reg, m_sample_next;
    logic [stc_pkg::POS_W-1:0]       m_pos_reg, m_pos_next;
    logic                            m_last_reg, m_last_next;

    logic                            in_fire;
    logic                            store_fire;
    logic                            cap_fire;
    logic                            issuing;
    logic                            hit;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_fire    = s_tvalid && s_tready;
    assign store_fire = in_fire && (s_tuser == stc_pkg::ACT_STORE);
    assign cap_fire   = in_fire && (s_tuser == stc_pkg::ACT_CAPTURE);

    // One candidate read per cycle, one more than the span to fetch the oldest predecessor.
    assign issuing = (state_reg == ST_SEARCH) && (issue_reg <= stc_pkg::SPAN_LAST);
    assign hit     = stc_pkg::is_edge(last_q_reg, ring_data, cfg);

    // Ring access: stores write, search and window steps read.
    always_comb begin
        ring_req         = '0;
        ring_req.wr_en   = store_fire;
        ring_req.wr_addr = newest_reg + 1'b1;
        ring_req.wr_data = s_tdata[stc_pkg::SAMPLE_W-1:0];
        if (issuing) begin
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = start_reg - issue_reg;
        end else if (state_reg == ST_WIN_RD) begin
            ring_req.rd_en   = 1'b1;
            ring_req.rd_addr = begin_reg + stc_pkg::ADDR_W'(pos_reg);
        end
    end

    // Next-state logic of the sequencer.
    always_comb begin
        state_next     = state_reg;
        newest_next    = newest_reg;
        err_next       = err_reg;
        start_next     = start_reg;
        issue_next     = issue_reg;
        chk_valid_next = 1'b0;
        chk_last_next  = 1'b0;
        chk_t_next     = chk_t_reg;
        last_q_next    = last_q_reg;
        begin_next     = begin_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        m_valid_next   = m_valid_reg;
        m_sample_next  = m_sample_reg;
        m_pos_next     = m_pos_reg;
        m_last_next    = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (store_fire) begin
                    newest_next = newest_reg + 1'b1;
                    if (s_tdata[stc_pkg::SAMPLE_W] && (err_reg != stc_pkg::ERR_MAX)) begin
                        err_next = err_reg + 1'b1;
                    end
                end
                if (cap_fire) begin
                    start_next = newest_reg - stc_pkg::HALF_WIN_A;
                    issue_next = '0;
                    state_next = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // The previous read's predecessor pairs with the sample read before it.
                last_q_next = ring_data;
                if (issuing) begin
                    issue_next     = issue_reg + 1'b1;
                    chk_valid_next = (issue_reg != '0);
                    chk_last_next  = (issue_reg == stc_pkg::SPAN_LAST);
                    chk_t_next     = start_reg - issue_reg + 1'b1;
                end
                if (chk_valid_reg && hit) begin
                    found_next     = 1'b1;
                    begin_next     = chk_t_reg - stc_pkg::HALF_WIN_A;
                    pos_next       = '0;
                    chk_valid_next = 1'b0;
                    state_next     = ST_WIN_RD;
                end else if (chk_valid_reg && chk_last_reg) begin
                    found_next     = 1'b0;
                    begin_next     = start_reg - stc_pkg::HALF_WIN_A;
                    pos_next       = '0;
                    chk_valid_next = 1'b0;
                    state_next     = ST_WIN_RD;
                end
            end
            ST_WIN_RD: begin
                state_next = ST_WIN_LOAD;
            end
            ST_WIN_LOAD: begin
                m_sample_next = ring_data;
                m_pos_next    = pos_reg;
                m_last_next   = (pos_reg == stc_pkg::POS_LAST);
                m_valid_next  = 1'b1;
                state_next    = ST_WIN_SEND;
            end
            ST_WIN_SEND: begin
                if (m_tready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = ST_IDLE;
                    end else begin
                        pos_next   = pos_reg + 1'b1;
                        state_next = ST_WIN_RD;
                    end
                end
            end
            default: begin
                state_next   = ST_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            newest_reg    <= stc_pkg::NEWEST_RESET;
            err_reg       <= '0;
            chk_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            newest_reg    <= newest_next;
            err_reg       <= err_next;
            chk_valid_reg <= chk_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        start_reg    <= start_next;
        issue_reg    <= issue_next;
        chk_last_reg <= chk_last_next;
        chk_t_reg    <= chk_t_next;
        last_q_reg   <= last_q_next;
        begin_reg    <= begin_next;
        pos_reg      <= pos_next;
        found_reg    <= found_next;
        m_sample_reg <= m_sample_next;
        m_pos_reg    <= m_pos_next;
        m_last_reg   <= m_last_next;
    end

    // Result beat: the error count cannot change while a window is out.
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(stc_pkg::M_TDATA_W - stc_pkg::SAMPLE_W - stc_pkg::POS_W
                         - stc_pkg::ERR_W){1'b0}},
                       err_reg, m_pos_reg, m_sample_reg};
    assign m_tuser  = found_reg;
    assign m_tlast  = m_last_reg;

endmodule

FILE: hdl/scope_trigger_capture.sv
// Top level of the scope trigger capture block: settings registers, controller and sample ring.
//
// A store beat (tuser 0) never holds the input, so samples stream in back to back while no
// capture is running. A capture beat (tuser 1) closes the input until its window is out: the
// backward search reads the ring once per candidate through its single read port, and each of
// the 64 window beats then passes through read, load and send plus any stall on m_tready.
// The ring needs no clearing pass after reset: a fill count makes entries never written read
// as zero.
module scope_trigger_capture (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Settings write port.
    input  logic                            cfg_wr_en,
    input  logic [stc_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    // Input stream.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [stc_pkg::S_TDATA_W-1:0]   s_tdata,  // [11:0] sample_in, [12] overflow_seen
    input  logic                            s_tuser,  // action
    // Result stream.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [stc_pkg::M_TDATA_W-1:0]   m_tdata,  // [11:0] sample_out,
                                                      // [17:12] window_position,
                                                      // [33:18] errors_so_far
    output logic                            m_tuser,  // edge_found
    output logic                            m_tlast   // last
);

    stc_pkg::cfg_t                  cfg_reg, cfg_next;
    stc_pkg::ring_req_t             ring_req;
    logic [stc_pkg::SAMPLE_W-1:0]   ring_data;

    // Settings registers; writes to unknown indexes are dropped.
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                stc_pkg::CFG_TRIGGER_LEVEL: cfg_next.level  = cfg_wr_data[stc_pkg::SAMPLE_W-1:0];
                stc_pkg::CFG_RISING_EDGE:   cfg_next.rising = cfg_wr_data[0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level  <= stc_pkg::LEVEL_RESET;
            cfg_reg.rising <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    stc_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .ring_req  (ring_req),
        .ring_data (ring_data)
    );

    stc_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ring_req),
        .rd_data (ring_data)
    );

endmodule

FILE: hdl/stc_checker.sv
// Port-level checker of the scope trigger capture block and its bind to the top level.
`include "scope_trigger_capture_assert.svh"

module stc_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            cfg_wr_en,
    input logic [stc_pkg::CFG_IDX_W-1:0]   cfg_wr_index,
    input logic [stc_pkg::CFG_DATA_W-1:0]  cfg_wr_data,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [stc_pkg::S_TDATA_W-1:0]   s_tdata,
    input logic                            s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [stc_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // A stalled result beat keeps its contents.
    `STC_ASSERT(a_stall_hold, aclk, aresetn, (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)), "result beat changed under stall")

    // No input beat is taken while a window is being delivered.
    `STC_ASSERT_NEVER(a_no_overlap, aclk, aresetn, s_tready && m_tvalid, "input open during window")

    // The last beat of a window carries the final window position.
    `STC_ASSERT(a_last_pos, aclk, aresetn, (m_tvalid && m_tlast) |-> (m_tdata[17:12] == stc_pkg::POS_LAST), "last beat at wrong position")

    // Reset leaves no result pending.
    `STC_ASSERT(a_reset_idle, aclk, aresetn, $past(!aresetn) |-> (!m_tvalid && s_tready), "block not idle after reset")

endmodule

bind scope_trigger_capture stc_checker u_stc_checker (.*);
